// ===== hdl/sdfrm_pkg.sv =====
// Shared types and constants of the 2-D signed distance ray marcher.
`default_nettype none
package sdfrm_pkg;

  // Shape kinds held in a table slot
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  // Stop causes
  localparam logic [1:0] CAUSE_SURFACE = 2'd0;
  localparam logic [1:0] CAUSE_OFFSCR  = 2'd1;
  localparam logic [1:0] CAUSE_STEPS   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_EPS    = 2'd2;

  // Post operation applied to a root
  localparam logic [1:0] POST_PLAIN = 2'd0;
  localparam logic [1:0] POST_HALF  = 2'd1;

  localparam int COORD_W   = 20;
  localparam int SIZE_W    = 19;
  localparam int OP_W      = 26;
  localparam int SQ_W      = 2 * OP_W;
  localparam int DIST_W    = 28;
  localparam int T_W       = 25;
  localparam int DIR_SHIFT = 14;
  localparam int FAR_PIXELS = 100000;

  // Payload of one table slot
  typedef struct packed {
    logic [7:0]         id;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } shape_t;

  // Request to the distance unit
  typedef struct packed {
    logic signed [OP_W-1:0]   a;
    logic signed [OP_W-1:0]   b;
    logic [1:0]               post;
    logic signed [DIST_W-1:0] off;
  } dreq_t;

endpackage
`default_nettype wire

// ===== hdl/sdfrm_cell.sv =====
// One table slot of the shape ring: holds a shape and hands it to its neighbour on rotation.
`default_nettype none
module sdfrm_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift,
  input  wire logic               wr,
  input  wire logic [1:0]         wr_kind,
  input  wire sdfrm_pkg::shape_t  wr_shape,
  input  wire logic [1:0]         nb_kind,
  input  wire sdfrm_pkg::shape_t  nb_shape,
  output logic [1:0]              kind,
  output sdfrm_pkg::shape_t       shape
);
  import sdfrm_pkg::*;

  logic [1:0] kind_r;
  shape_t     shape_r;

  // Hold kind, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_EMPTY;
    end else if (wr) begin
      kind_r <= wr_kind;
    end else if (shift) begin
      kind_r <= nb_kind;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (wr) begin
      shape_r <= wr_shape;
    end else if (shift) begin
      shape_r <= nb_shape;
    end
  end

  assign kind  = kind_r;
  assign shape = shape_r;
endmodule
`default_nettype wire

// ===== hdl/sdfrm_dist.sv =====
// Distance unit: squares, bit-serial floor root, offset and optional halving of one distance request.
`default_nettype none
module sdfrm_dist (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire sdfrm_pkg::dreq_t                req,
  output logic                                 done,
  output logic signed [sdfrm_pkg::DIST_W-1:0]  res
);
  import sdfrm_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_SUM  = 3'd2;
  localparam logic [2:0] PH_ROOT = 3'd3;
  localparam logic [2:0] PH_POST = 3'd4;
  localparam int CNT_W = $clog2(OP_W + 1);

  logic [2:0]               ph_r;
  dreq_t                    req_r;
  logic [SQ_W-1:0]          sa_r, sb_r, v_r, r_r, bit_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     done_r;
  logic signed [DIST_W-1:0] res_r;
  logic [SQ_W-1:0]          trial;
  logic signed [DIST_W-1:0] sum;

  assign trial = r_r + bit_r;
  assign sum   = $signed({{(DIST_W-OP_W){1'b0}}, r_r[OP_W-1:0]}) + req_r.off;

  // Sequence the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: if (start) ph_r <= PH_MUL;
        PH_MUL:  ph_r <= PH_SUM;
        PH_SUM:  ph_r <= PH_ROOT;
        PH_ROOT: if (cnt_r == CNT_W'(1)) ph_r <= PH_POST;
        PH_POST: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  // Datapath: one root bit a cycle
  always_ff @(posedge clk) begin
    case (ph_r)
      PH_IDLE: if (start) req_r <= req;
      PH_MUL: begin
        sa_r <= SQ_W'(req_r.a * req_r.a);
        sb_r <= SQ_W'(req_r.b * req_r.b);
      end
      PH_SUM: begin
        v_r   <= sa_r + sb_r;
        r_r   <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        cnt_r <= CNT_W'(OP_W);
      end
      PH_ROOT: begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      PH_POST: begin
        if (req_r.post == POST_HALF) res_r <= sum >>> 1;
        else res_r <= sum;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

// ===== hdl/sdf_ray_marcher_2d_unit.sv =====
// Top level of the 2-D signed distance ray marcher.
// Usage:
//  - Input requests are taken on a clock edge with start high and busy low.
//    in_operation 0 writes a shape into slot in_slot in that same cycle and
//    gives no result; in_operation 1 casts a ray from (in_pos_x, in_pos_y)
//    along (in_dir_x, in_dir_y) and raises busy until its result is out.
//  - A result is shown for one cycle with out_valid high; the receiver
//    cannot stall it.
//  - Shapes live in a ring of cells; each march step rotates the ring once
//    through the head cell, which feeds a shared distance unit, then three
//    more distance requests cover the screen corners.
//  - Each filled slot and each corner costs a full request to the distance
//    unit with its bit-serial root; empty slots are only rotated past. A ray
//    runs up to MAX_STEPS march steps; its result shows in the cycle in which
//    busy falls, and a new request can already be taken in that cycle.
//  - Configuration goes through the APB port while idle; pready is tied high.
//  - Reset empties every slot and loads width 1024, height 768, epsilon 1.
`default_nettype none
module sdf_ray_marcher_2d_unit #(
  parameter int MAX_SHAPES = 16,
  parameter int MAX_STEPS  = 64,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [3:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_operation,
  input  wire logic [3:0]                            in_slot,
  input  wire logic [1:0]                            in_shape_kind,
  input  wire logic [7:0]                            in_shape_id,
  input  wire logic signed [19:0]                    in_pos_x,
  input  wire logic signed [19:0]                    in_pos_y,
  input  wire logic [18:0]                           in_size_w,
  input  wire logic [18:0]                           in_size_h,
  input  wire logic signed [15:0]                    in_dir_x,
  input  wire logic signed [15:0]                    in_dir_y,
  output logic                                       out_valid,
  output logic signed [19:0]                         out_hit_x,
  output logic signed [19:0]                         out_hit_y,
  output logic [7:0]                                 out_hit_id,
  output logic                                       out_hit_wall,
  output logic [1:0]                                 out_stop_cause
);
  import sdfrm_pkg::*;

  localparam int IDX_W  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CNT_W  = $clog2(MAX_SHAPES + 1);
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int SCR_W  = 15 + FRAC_BITS;
  localparam int PROD_W = T_W + 17;
  localparam int PT_W   = PROD_W - DIR_SHIFT + 1;
  localparam logic [T_W-1:0] T_LIMIT = T_W'(1) << 24;
  localparam logic signed [DIST_W-1:0] FAR_DIST = DIST_W'(FAR_PIXELS) <<< FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_PT    = 3'd2;
  localparam logic [2:0] ST_SHP   = 3'd3;
  localparam logic [2:0] ST_SWAIT = 3'd4;
  localparam logic [2:0] ST_WALL  = 3'd5;
  localparam logic [2:0] ST_WWAIT = 3'd6;
  localparam logic [2:0] ST_DEC   = 3'd7;

  // Configuration registers
  logic [14:0] width_r, height_r;
  logic [7:0]  eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd1024;
      height_r <= 15'd768;
      eps_r    <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[14:0];
        REG_HEIGHT: height_r <= pwdata[14:0];
        REG_EPS:    eps_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {17'd0, width_r};
      REG_HEIGHT: prdata = {17'd0, height_r};
      REG_EPS:    prdata = {24'd0, eps_r};
      default:    prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;

  // Control and march state
  logic [2:0]               st_r;
  logic signed [19:0]       ox_r, oy_r, px_r, py_r;
  logic signed [15:0]       dx_r, dy_r;
  logic [T_W-1:0]           t_r;
  logic signed [PROD_W-1:0] prx_r, pry_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [1:0]               wcnt_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [DIST_W-1:0] best_r, wd_r;
  logic [7:0]               bid_r;
  logic                     accept, shift, dstart;
  dreq_t                    dreq;
  logic                     ddone;
  logic signed [DIST_W-1:0] dres;

  assign accept = start && !busy;
  assign busy   = (st_r != ST_IDLE);

  // Shape ring
  logic [1:0] ck [MAX_SHAPES];
  shape_t     cs [MAX_SHAPES];
  shape_t     wr_shape;
  logic [1:0] wr_kind;

  assign wr_shape = '{id: in_shape_id, cx: in_pos_x, cy: in_pos_y, w: in_size_w, h: in_size_h};
  assign wr_kind  = (in_shape_kind == 2'd3) ? KIND_EMPTY : in_shape_kind;

  for (genvar g = 0; g < MAX_SHAPES; g++) begin : g_ring
    logic wr_g;
    assign wr_g = accept && !in_operation && (32'(in_slot) < 32'(MAX_SHAPES))
                  && (IDX_W'(in_slot) == IDX_W'(g));
    sdfrm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .wr       (wr_g),
      .wr_kind  (wr_kind),
      .wr_shape (wr_shape),
      .nb_kind  (ck[(g + 1) % MAX_SHAPES]),
      .nb_shape (cs[(g + 1) % MAX_SHAPES]),
      .kind     (ck[g]),
      .shape    (cs[g])
    );
  end

  // Operands for the head shape
  logic signed [20:0] hdx, hdy;
  logic [20:0]        adx, ady;
  logic signed [22:0] qx, qy, qmax;
  logic signed [OP_W-1:0] cxa, cya;

  always_comb begin
    hdx  = $signed({px_r[19], px_r}) - $signed({cs[0].cx[19], cs[0].cx});
    hdy  = $signed({py_r[19], py_r}) - $signed({cs[0].cy[19], cs[0].cy});
    adx  = hdx[20] ? 21'(-hdx) : hdx;
    ady  = hdy[20] ? 21'(-hdy) : hdy;
    qx   = $signed({1'b0, adx, 1'b0}) - $signed({4'd0, cs[0].w});
    qy   = $signed({1'b0, ady, 1'b0}) - $signed({4'd0, cs[0].h});
    qmax = (qx > qy) ? qx : qy;
    cxa  = OP_W'(qx < 0 ? 23'sd0 : qx);
    cya  = OP_W'(qy < 0 ? 23'sd0 : qy);
  end

  // Corner points of the wall term
  logic signed [OP_W-1:0] wx, wy, pxe, pye;
  assign wx  = $signed(OP_W'(SCR_W'(width_r) << FRAC_BITS));
  assign wy  = $signed(OP_W'(SCR_W'(height_r) << FRAC_BITS));
  assign pxe = OP_W'(px_r);
  assign pye = OP_W'(py_r);

  always_comb begin
    dreq = '{a: OP_W'(hdx), b: OP_W'(hdy), post: POST_PLAIN,
             off: -$signed({{(DIST_W-SIZE_W){1'b0}}, cs[0].w})};
    if (st_r == ST_WALL) begin
      dreq.post = POST_PLAIN;
      dreq.off  = '0;
      case (wcnt_r)
        2'd0:    begin dreq.a = pxe - wx; dreq.b = pye; end
        2'd1:    begin dreq.a = pxe;      dreq.b = pye; end
        default: begin dreq.a = pxe;      dreq.b = pye - wy; end
      endcase
    end else if (ck[0] == KIND_BOX) begin
      dreq.a    = cxa;
      dreq.b    = cya;
      dreq.post = POST_HALF;
      dreq.off  = (qmax > 0) ? '0 : DIST_W'(qmax);
    end
  end

  assign dstart = (st_r == ST_WALL) ||
                  (st_r == ST_SHP && cnt_r != CNT_W'(MAX_SHAPES) && ck[0] != KIND_EMPTY);
  assign shift  = (st_r == ST_SHP && cnt_r != CNT_W'(MAX_SHAPES) && ck[0] == KIND_EMPTY) ||
                  (st_r == ST_SWAIT && ddone);

  sdfrm_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart),
    .req   (dreq),
    .done  (ddone),
    .res   (dres)
  );

  // Point of the step, saturated to the coordinate range
  logic signed [PT_W-1:0] sx, sy;
  logic signed [19:0]     satx, saty;
  assign sx = $signed({{(PT_W-20){ox_r[19]}}, ox_r})
            + PT_W'((prx_r + PROD_W'(1 << (DIR_SHIFT - 1))) >>> DIR_SHIFT);
  assign sy = $signed({{(PT_W-20){oy_r[19]}}, oy_r})
            + PT_W'((pry_r + PROD_W'(1 << (DIR_SHIFT - 1))) >>> DIR_SHIFT);
  assign satx = (sx > PT_W'(524287)) ? 20'sd524287 :
                (sx < -PT_W'(524288)) ? -20'sd524288 : 20'(sx);
  assign saty = (sy > PT_W'(524287)) ? 20'sd524287 :
                (sy < -PT_W'(524288)) ? -20'sd524288 : 20'(sy);

  // Step decision
  logic                     wall_win, offscr;
  logic signed [DIST_W-1:0] dfin;
  logic [DIST_W-1:0]        dabs;
  logic [DIST_W:0]          tsum;
  assign wall_win = (wd_r <= best_r);
  assign dfin     = wall_win ? wd_r : best_r;
  assign dabs     = dfin[DIST_W-1] ? DIST_W'(-dfin) : dfin;
  assign tsum     = (DIST_W+1)'(t_r) + (DIST_W+1)'(dabs);
  assign offscr   = px_r < 0 || py_r < 0 ||
                    OP_W'(px_r) > wx || OP_W'(py_r) > wy;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (accept && in_operation) begin
            ox_r   <= in_pos_x;
            oy_r   <= in_pos_y;
            dx_r   <= in_dir_x;
            dy_r   <= in_dir_y;
            t_r    <= '0;
            step_r <= '0;
            st_r   <= ST_MUL;
          end
        end
        ST_MUL: begin
          prx_r <= PROD_W'($signed({1'b0, t_r}) * dx_r);
          pry_r <= PROD_W'($signed({1'b0, t_r}) * dy_r);
          st_r  <= ST_PT;
        end
        ST_PT: begin
          px_r   <= satx;
          py_r   <= saty;
          best_r <= FAR_DIST;
          bid_r  <= 8'd0;
          cnt_r  <= '0;
          st_r   <= ST_SHP;
        end
        ST_SHP: begin
          if (cnt_r == CNT_W'(MAX_SHAPES)) begin
            wcnt_r <= 2'd0;
            st_r   <= ST_WALL;
          end else if (ck[0] == KIND_EMPTY) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            st_r <= ST_SWAIT;
          end
        end
        ST_SWAIT: begin
          if (ddone) begin
            if (dres < best_r) begin
              best_r <= dres;
              bid_r  <= cs[0].id;
            end
            cnt_r <= cnt_r + CNT_W'(1);
            st_r  <= ST_SHP;
          end
        end
        ST_WALL: st_r <= ST_WWAIT;
        ST_WWAIT: begin
          if (ddone) begin
            if (wcnt_r == 2'd0 || dres < wd_r) wd_r <= dres;
            if (wcnt_r == 2'd2) begin
              st_r <= ST_DEC;
            end else begin
              wcnt_r <= wcnt_r + 2'd1;
              st_r   <= ST_WALL;
            end
          end
        end
        ST_DEC: begin
          out_hit_x    <= px_r;
          out_hit_y    <= py_r;
          out_hit_id   <= wall_win ? 8'd0 : bid_r;
          out_hit_wall <= wall_win;
          if (dfin <= $signed({{(DIST_W-8){1'b0}}, eps_r})) begin
            out_stop_cause <= CAUSE_SURFACE;
            out_valid      <= 1'b1;
            st_r           <= ST_IDLE;
          end else if (offscr) begin
            out_stop_cause <= CAUSE_OFFSCR;
            out_valid      <= 1'b1;
            st_r           <= ST_IDLE;
          end else if (step_r == STEP_W'(MAX_STEPS - 1)) begin
            out_stop_cause <= CAUSE_STEPS;
            out_valid      <= 1'b1;
            st_r           <= ST_IDLE;
          end else begin
            t_r    <= (tsum > (DIST_W+1)'(T_LIMIT)) ? T_LIMIT : T_W'(tsum);
            step_r <= step_r + STEP_W'(1);
            st_r   <= ST_MUL;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the 2-D signed distance ray marcher.
`default_nettype none
module testbench;
  import sdfrm_pkg::*;

  localparam int  N_SLOTS     = 16;
  localparam int  STEP_LIMIT  = 64;
  localparam int  FRAC        = 4;
  localparam longint CYCLE_LIMIT = 60_000_000;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RAY   = 1'b1;
  localparam int  UNIT_DIR  = 16384;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [7:0]         id;
    logic               wall;
    logic [1:0]         cause;
  } hit_t;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  logic in_operation;
  logic [3:0] in_slot;
  logic [1:0] in_shape_kind;
  logic [7:0] in_shape_id;
  logic signed [19:0] in_pos_x, in_pos_y;
  logic [18:0] in_size_w, in_size_h;
  logic signed [15:0] in_dir_x, in_dir_y;
  logic out_valid;
  logic signed [19:0] out_hit_x, out_hit_y;
  logic [7:0] out_hit_id;
  logic out_hit_wall;
  logic [1:0] out_stop_cause;

  sdf_ray_marcher_2d_unit dut (.*);

  // Scene and register copies used for prediction
  logic [1:0]  scn_kind [N_SLOTS];
  logic [7:0]  scn_id   [N_SLOTS];
  longint      scn_cx [N_SLOTS], scn_cy [N_SLOTS], scn_w [N_SLOTS], scn_h [N_SLOTS];
  longint      scr_w, scr_h, eps;
  hit_t        hits_due[$];
  int          mismatches;
  longint      cycles;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root
  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint span(longint a, longint b);
    return root_floor(longint'(a * a) + longint'(b * b));
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp20(longint v);
    if (v < -524288) return -524288;
    if (v > 524287) return 524287;
    return v;
  endfunction

  // Scene distance at a point; nearest id and wall flag returned too
  function automatic longint scene_dist(longint px, longint py, longint wd16, longint ht16,
                                        output logic [7:0] nid, output logic wall);
    longint best, d, wd, t, qx, qy, inner;
    best = longint'(FAR_PIXELS) << FRAC;
    nid = 8'd0;
    for (int k = 0; k < N_SLOTS; k++) begin
      if (scn_kind[k] == KIND_CIRCLE) begin
        d = span(px - scn_cx[k], py - scn_cy[k]) - scn_w[k];
      end else if (scn_kind[k] == KIND_BOX) begin
        qx = 2 * mag(px - scn_cx[k]) - scn_w[k];
        qy = 2 * mag(py - scn_cy[k]) - scn_h[k];
        inner = qx > qy ? qx : qy;
        if (inner > 0) inner = 0;
        d = (span(qx > 0 ? qx : 0, qy > 0 ? qy : 0) + inner) >>> 1;
      end else begin
        continue;
      end
      if (d < best) begin
        best = d;
        nid = scn_id[k];
      end
    end
    wd = span(px - wd16, py);
    t = span(px, py);
    if (t < wd) wd = t;
    t = span(px, py - ht16);
    if (t < wd) wd = t;
    wall = 1'b0;
    if (wd <= best) begin
      nid = 8'd0;
      wall = 1'b1;
      return wd;
    end
    return best;
  endfunction

  // March one ray through the scene copy
  function automatic hit_t march_ray(longint ox, longint oy, longint dx, longint dy);
    hit_t r;
    longint t, d, px, py, wd16, ht16;
    logic [7:0] nid;
    logic wall;
    t = 0;
    px = 0;
    py = 0;
    nid = 8'd0;
    wall = 1'b0;
    wd16 = scr_w << FRAC;
    ht16 = scr_h << FRAC;
    r.cause = CAUSE_STEPS;
    for (int s = 0; s < STEP_LIMIT; s++) begin
      px = clamp20(ox + ((t * dx + (64'sd1 << (DIR_SHIFT - 1))) >>> DIR_SHIFT));
      py = clamp20(oy + ((t * dy + (64'sd1 << (DIR_SHIFT - 1))) >>> DIR_SHIFT));
      d = scene_dist(px, py, wd16, ht16, nid, wall);
      if (d <= eps) begin
        r.cause = CAUSE_SURFACE;
        break;
      end
      if (px < 0 || px > wd16 || py < 0 || py > ht16) begin
        r.cause = CAUSE_OFFSCR;
        break;
      end
      t += mag(d);
      if (t > (64'sd1 << 24)) t = 64'sd1 << 24;
    end
    r.x = px[19:0];
    r.y = py[19:0];
    r.id = nid;
    r.wall = wall;
    return r;
  endfunction

  // Drop start for a random gap: mostly none or short, a few long
  task automatic idle_gap();
    int n, roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold start and payload until the request is taken, then predict
  task automatic send_request(logic op, logic [3:0] slot, logic [1:0] kind, logic [7:0] id,
                              longint px, longint py, longint sw, longint sh,
                              longint dx, longint dy);
    start <= 1'b1;
    in_operation <= op;
    in_slot <= slot;
    in_shape_kind <= kind;
    in_shape_id <= id;
    in_pos_x <= px[19:0];
    in_pos_y <= py[19:0];
    in_size_w <= sw[18:0];
    in_size_h <= sh[18:0];
    in_dir_x <= dx[15:0];
    in_dir_y <= dy[15:0];
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      scn_kind[slot] = (kind == 2'd3) ? KIND_EMPTY : kind;
      scn_id[slot] = id;
      scn_cx[slot] = longint'(signed'(px[19:0]));
      scn_cy[slot] = longint'(signed'(py[19:0]));
      scn_w[slot] = longint'(sw[18:0]);
      scn_h[slot] = longint'(sh[18:0]);
    end else begin
      hits_due.insert(hits_due.size(),
                      march_ray(longint'(signed'(px[19:0])), longint'(signed'(py[19:0])),
                                longint'(signed'(dx[15:0])), longint'(signed'(dy[15:0]))));
    end
    idle_gap();
  endtask

  // Wait for every expected hit and let the block settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (hits_due.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        scr_w = val[14:0];
        want = {17'd0, val[14:0]};
      end
      REG_HEIGHT: begin
        scr_h = val[14:0];
        want = {17'd0, val[14:0]};
      end
      REG_EPS: begin
        eps = val[7:0];
        want = {24'd0, val[7:0]};
      end
      default: want = 32'd0;
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want || pready !== 1'b1) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read: want %0h, got %0h", idx, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_screen(longint w, longint h, longint e);
    drain();
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    reg_write(REG_EPS, 32'(e));
  endtask

  task automatic cast(longint px, longint py, longint dx, longint dy);
    send_request(OP_RAY, 4'd0, KIND_EMPTY, 8'd0, px, py, 0, 0, dx, dy);
  endtask

  // Random unit direction in Q1.14
  task automatic unit_dir(output longint dx, output longint dy);
    dx = longint'($urandom_range(0, 2 * UNIT_DIR)) - UNIT_DIR;
    dy = root_floor(longint'(UNIT_DIR) * UNIT_DIR - dx * dx);
    if ($urandom_range(0, 1)) dy = -dy;
  endtask

  task automatic clear_scene();
    for (int k = 0; k < N_SLOTS; k++)
      send_request(OP_WRITE, 4'(k), KIND_EMPTY, 8'd0, 0, 0, 0, 0, 0, 0);
  endtask

  // Empty scene: wall term only, corners, off-screen start, extreme directions
  task automatic test_wall_only();
    cast(10 * 16, 10 * 16, UNIT_DIR, 0);
    cast(0, 0, 0, UNIT_DIR);
    cast(1024 * 16, 0, -UNIT_DIR, 0);
    cast(-5 * 16, 40 * 16, UNIT_DIR, 0);
    cast(500 * 16, 400 * 16, 0, -UNIT_DIR);
    cast(300 * 16, 300 * 16, 0, 0);
    cast(524287, 524287, -UNIT_DIR, -UNIT_DIR);
    cast(-524288, -524288, UNIT_DIR, UNIT_DIR);
  endtask

  // Directed shapes: circle, box, inside a box, kind 3, extreme fields
  task automatic test_shapes();
    send_request(OP_WRITE, 4'd0, KIND_CIRCLE, 8'd7, 200 * 16, 200 * 16, 50 * 16, 0, 0, 0);
    send_request(OP_WRITE, 4'd1, KIND_BOX, 8'd9, 600 * 16, 300 * 16, 100 * 16, 60 * 16, 0, 0);
    send_request(OP_WRITE, 4'd5, 2'd3, 8'd255, 100 * 16, 100 * 16, 90 * 16, 90 * 16, 0, 0);
    send_request(OP_WRITE, 4'd15, KIND_BOX, 8'hFF, 524287, -524288, 524287, 524287, 0, 0);
    cast(20 * 16, 200 * 16, UNIT_DIR, 0);
    cast(600 * 16, 20 * 16, 0, UNIT_DIR);
    cast(600 * 16, 300 * 16, 11585, 11585);
    cast(200 * 16, 200 * 16, -UNIT_DIR, 0);
    cast(900 * 16, 700 * 16, -11585, -11585);
    send_request(OP_WRITE, 4'd15, KIND_CIRCLE, 8'h80, -524288, 524287, 0, 0, 0, 0);
    cast(50 * 16, 700 * 16, 0, -UNIT_DIR);
    clear_scene();
  endtask

  // Random scenes followed by rays, under one screen setting
  task automatic test_random_scenes(int n_rays);
    longint w16, h16, dx, dy, rmax;
    int sent;
    w16 = scr_w << FRAC;
    h16 = scr_h << FRAC;
    rmax = (w16 < h16 ? w16 : h16) / 4 + 1;
    sent = 0;
    while (sent < n_rays) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0)
          send_request(OP_WRITE, 4'($urandom), 2'($urandom), 8'($urandom), 20'($urandom),
                       20'($urandom), 19'($urandom), 19'($urandom), 0, 0);
        else
          send_request(OP_WRITE, 4'($urandom), 2'($urandom_range(1, 2)), 8'($urandom),
                       $urandom_range(0, 32'(w16)), $urandom_range(0, 32'(h16)),
                       $urandom_range(0, 32'(rmax)), $urandom_range(0, 32'(2 * rmax)), 0, 0);
      end
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) == 0) begin
          dx = longint'($urandom_range(0, 2 * UNIT_DIR)) - UNIT_DIR;
          dy = longint'($urandom_range(0, 2 * UNIT_DIR)) - UNIT_DIR;
          cast(longint'(signed'(20'($urandom))), longint'(signed'(20'($urandom))), dx, dy);
        end else begin
          unit_dir(dx, dy);
          cast($urandom_range(0, 32'(w16)), $urandom_range(0, 32'(h16)), dx, dy);
        end
        sent++;
      end
    end
    clear_scene();
  endtask

  // Compare each hit with the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid) begin
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hit at cycle %0d", cycles);
      end else begin
        want = hits_due.pop_front();
        if (out_hit_x !== want.x || out_hit_y !== want.y || out_hit_id !== want.id ||
            out_hit_wall !== want.wall || out_stop_cause !== want.cause) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hit mismatch: want x=%0d y=%0d id=%0d wall=%0b cause=%0d,",
                     want.x, want.y, want.id, want.wall, want.cause,
                     " got x=%0d y=%0d id=%0d wall=%0b cause=%0d",
                     out_hit_x, out_hit_y, out_hit_id, out_hit_wall, out_stop_cause);
        end
      end
    end
  end

  // Cycle watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sdf_ray_marcher_2d_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    no_gaps = 1'b0;
    scr_w = 1024;
    scr_h = 768;
    eps = 1;
    for (int k = 0; k < N_SLOTS; k++) begin
      scn_kind[k] = KIND_EMPTY;
      scn_id[k] = 8'd0;
      scn_cx[k] = 0;
      scn_cy[k] = 0;
      scn_w[k] = 0;
      scn_h[k] = 0;
    end
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    in_operation = OP_WRITE;
    in_slot = '0;
    in_shape_kind = KIND_EMPTY;
    in_shape_id = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_size_w = '0;
    in_size_h = '0;
    in_dir_x = '0;
    in_dir_y = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wall_only();
    test_shapes();
    test_random_scenes(20);
    no_gaps = 1'b1;
    set_screen(32767, 32767, 255);
    test_random_scenes(12);
    no_gaps = 1'b0;
    set_screen(1, 1, 0);
    test_wall_only();
    test_random_scenes(10);
    set_screen(200, 150, 8);
    test_random_scenes(15);
    set_screen(4000, 3000, 3);
    test_random_scenes(15);
    set_screen(1024, 768, 1);
    test_random_scenes(15);

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && hits_due.size() == 0)
      $display("** sdf_ray_marcher_2d_unit: PASSED **");
    else
      $display("** sdf_ray_marcher_2d_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
